// ===== hw/rtl/tbik_pkg.sv =====
// ----------------------------------------------------------------------------
// tbik_pkg
// Shared widths, register codes, item types and helpers of the two-bone IK
// solver.
// ----------------------------------------------------------------------------
package tbik_pkg;

  localparam int unsigned CoordW       = 32;
  localparam int unsigned BendW        = 18;
  localparam int unsigned LenW         = 31;
  localparam int unsigned DistW        = 33;
  localparam int unsigned QuoW         = 32;
  localparam int unsigned NumW         = 65;
  localparam int unsigned AccW         = 36;
  localparam int unsigned CfgIdxW      = 4;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned FifoDepthDef = 4;
  localparam int unsigned FracW        = 16;

  localparam logic [DistW-1:0] LenFloor = DistW'(7);
  localparam logic [49:0]      RoundHalf = 50'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    CfgUpperLength = CfgIdxW'(0),
    CfgLowerLength = CfgIdxW'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [LenW-1:0] upper;
    logic [LenW-1:0] lower;
  } cfg_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] root;
    logic [2:0][CoordW-1:0] goal;
    logic [2:0][BendW-1:0]  bend;
    logic [2:0][CoordW-1:0] mag;
    logic [2:0]             neg;
    logic [DistW-1:0]       dlen;
    logic                   reach_out;
  } cls_item_t;

  typedef struct packed {
    cls_item_t         item;
    logic [2*LenW-1:0] uu;
    logic              ovf;
    logic              neg;
  } p_side_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] root;
    logic [2:0][CoordW-1:0] goal;
    logic [2:0][BendW-1:0]  bend;
    logic                   reach_out;
  } h_side_t;

  function automatic logic [CoordW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic [CoordW-1:0] r;
    if (v > $signed(AccW'(32'h7fff_ffff))) begin
      r = 32'h7fff_ffff;
    end else if (v < -$signed(AccW'(33'h0_8000_0000))) begin
      r = 32'h8000_0000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/two_bone_ik_solver.sv =====
// ----------------------------------------------------------------------------
// two_bone_ik_solver
// Analytic two-bone inverse kinematics in signed Q16.16 with saturation.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   cfg     | cfg_valid_i/ready_o, cfg_index_i, data   | in
//   in      | in_valid_i/ready_o, root/goal/bend xyz   | in
//   out     | out_valid_o/ready_i, joint/end xyz, flag | out
//
// One beat per cycle while the output is not stalled; the path runs through
// the bit-per-stage distance square root, the cosine divider and the
// parallel sine square root and scaling dividers.
// Reset gives both lengths 1.0 and an empty pipeline; no clearing pass.
// An output stall freezes the back pipeline; the queue then fills and the
// front stalls, which drops in_ready_o.
// ----------------------------------------------------------------------------
module two_bone_ik_solver #(
  parameter int unsigned FifoDepth = tbik_pkg::FifoDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbik_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tbik_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [31:0]              root_x_i,
  input  logic signed [31:0]              root_y_i,
  input  logic signed [31:0]              root_z_i,
  input  logic signed [31:0]              goal_x_i,
  input  logic signed [31:0]              goal_y_i,
  input  logic signed [31:0]              goal_z_i,
  input  logic signed [17:0]              bend_x_i,
  input  logic signed [17:0]              bend_y_i,
  input  logic signed [17:0]              bend_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              joint_x_o,
  output logic signed [31:0]              joint_y_o,
  output logic signed [31:0]              joint_z_o,
  output logic signed [31:0]              end_x_o,
  output logic signed [31:0]              end_y_o,
  output logic signed [31:0]              end_z_o,
  output logic                            out_of_reach_o
);

  tbik_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0][tbik_pkg::CoordW-1:0] root, goal, joint, endp;
  logic [2:0][tbik_pkg::BendW-1:0]  bend;
  logic f_valid, f_ready, b_valid, b_ready;
  tbik_pkg::cls_item_t f_item, b_item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (tbik_pkg::cfg_reg_e'(cfg_index_i))
        tbik_pkg::CfgUpperLength: cfg_d.upper = cfg_data_i[tbik_pkg::LenW-1:0];
        tbik_pkg::CfgLowerLength: cfg_d.lower = cfg_data_i[tbik_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper <= tbik_pkg::LenW'(65536);
      cfg_q.lower <= tbik_pkg::LenW'(65536);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign root = {root_z_i, root_y_i, root_x_i};
  assign goal = {goal_z_i, goal_y_i, goal_x_i};
  assign bend = {bend_z_i, bend_y_i, bend_x_i};

  tbik_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .root_i     (root),
    .goal_i     (goal),
    .bend_i     (bend),
    .q_valid_o  (f_valid),
    .q_ready_i  (f_ready),
    .q_item_o   (f_item)
  );

  tbik_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_item_i  (f_item),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_item_o  (b_item)
  );

  tbik_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (b_valid),
    .q_ready_o      (b_ready),
    .q_item_i       (b_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .joint_o        (joint),
    .end_o          (endp),
    .out_of_reach_o (out_of_reach_o)
  );

  assign joint_x_o = joint[0];
  assign joint_y_o = joint[1];
  assign joint_z_o = joint[2];
  assign end_x_o   = endp[0];
  assign end_y_o   = endp[1];
  assign end_z_o   = endp[2];

endmodule

// ===== hw/rtl/tbik_sqrt.sv =====
// ----------------------------------------------------------------------------
// tbik_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tbik_sqrt #(
  parameter int unsigned RootW = 33,
  parameter int unsigned SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [RootW-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned RadW = 2 * RootW;

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RadW-1:0]  rad_q  [RootW];
  logic [SideW-1:0] side_q [RootW];
  logic             valid_q [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RemW-1:0]  rem_p;
    logic [RootW-1:0] root_p;
    logic [RadW-1:0]  rad_p;
    logic [SideW-1:0] side_p;
    logic             valid_p;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  rem_n;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_p   = '0;
      assign root_p  = '0;
      assign rad_p   = rad_i;
      assign side_p  = side_i;
      assign valid_p = valid_i;
    end else begin : g_next
      assign rem_p   = rem_q[s-1];
      assign root_p  = root_q[s-1];
      assign rad_p   = rad_q[s-1];
      assign side_p  = side_q[s-1];
      assign valid_p = valid_q[s-1];
    end

    always_comb begin
      rem_sh = {rem_p[RemW-3:0], rad_p[RadW-1 -: 2]};
      trial  = {root_p, 2'b01};
      ge     = rem_sh >= trial;
      rem_n  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_n;
        root_q[s] <= {root_p[RootW-2:0], ge};
        rad_q[s]  <= rad_p << 2;
        side_q[s] <= side_p;
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

// ===== hw/rtl/tbik_div.sv =====
// ----------------------------------------------------------------------------
// tbik_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// The high part of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module tbik_div #(
  parameter int unsigned NumW  = 65,
  parameter int unsigned DenW  = 33,
  parameter int unsigned QuoW  = 32,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic [DenW-1:0]  rem_q  [QuoW];
  logic [QuoW-1:0]  lq_q   [QuoW];
  logic [DenW-1:0]  den_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];
  logic             valid_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [DenW-1:0]  rem_p;
    logic [QuoW-1:0]  lq_p;
    logic [DenW-1:0]  den_p;
    logic [SideW-1:0] side_p;
    logic             valid_p;
    logic [DenW:0]    trial;
    logic [DenW:0]    diff;
    logic             ge;
    logic [DenW-1:0]  rem_n;

    if (s == 0) begin : g_first
      assign rem_p   = DenW'(num_i >> QuoW);
      assign lq_p    = num_i[QuoW-1:0];
      assign den_p   = den_i;
      assign side_p  = side_i;
      assign valid_p = valid_i;
    end else begin : g_next
      assign rem_p   = rem_q[s-1];
      assign lq_p    = lq_q[s-1];
      assign den_p   = den_q[s-1];
      assign side_p  = side_q[s-1];
      assign valid_p = valid_q[s-1];
    end

    always_comb begin
      trial = {rem_p, lq_p[QuoW-1]};
      diff  = trial - {1'b0, den_p};
      ge    = trial >= {1'b0, den_p};
      rem_n = ge ? diff[DenW-1:0] : trial[DenW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_n;
        lq_q[s]   <= {lq_p[QuoW-2:0], ge};
        den_q[s]  <= den_p;
        side_q[s] <= side_p;
      end
    end
  end

  assign valid_o = valid_q[QuoW-1];
  assign quo_o   = lq_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

// ===== hw/rtl/tbik_front.sv =====
// ----------------------------------------------------------------------------
// tbik_front
// Accepts poses, finds the root-to-goal distance and classifies reach.
// ----------------------------------------------------------------------------
module tbik_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tbik_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0][tbik_pkg::CoordW-1:0]     root_i,
  input  logic [2:0][tbik_pkg::CoordW-1:0]     goal_i,
  input  logic [2:0][tbik_pkg::BendW-1:0]      bend_i,
  output logic                                 q_valid_o,
  input  logic                                 q_ready_i,
  output tbik_pkg::cls_item_t                  q_item_o
);

  logic en;
  logic v1_q, v2_q, v4_q;
  tbik_pkg::cls_item_t it1_q, it2_q, it4_q, it1_d, sq_side;
  logic [2:0][63:0] sq2_q;
  logic [65:0] rad;
  logic        vs;
  logic [tbik_pkg::DistW-1:0] root_s;
  tbik_pkg::cls_item_t it_s;
  tbik_pkg::cls_item_t it4_d;
  logic [tbik_pkg::DistW-1:0] total;

  assign en         = !v4_q || q_ready_i;
  assign in_ready_o = en;

  always_comb begin
    logic signed [32:0] diff;
    it1_d = '0;
    it1_d.root = root_i;
    it1_d.goal = goal_i;
    it1_d.bend = bend_i;
    for (int i = 0; i < 3; i++) begin
      diff = 33'($signed(goal_i[i])) - 33'($signed(root_i[i]));
      it1_d.neg[i] = diff[32];
      it1_d.mag[i] = diff[32] ? 32'(-diff) : diff[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v4_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q <= it1_d;
      it2_q <= it1_q;
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= it1_q.mag[i] * it1_q.mag[i];
      end
      it4_q <= it4_d;
    end
  end

  assign rad     = 66'(sq2_q[0]) + 66'(sq2_q[1]) + 66'(sq2_q[2]);
  assign sq_side = it2_q;

  tbik_sqrt #(
    .RootW (tbik_pkg::DistW),
    .SideW ($bits(tbik_pkg::cls_item_t))
  ) u_dist_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (rad),
    .side_i  (sq_side),
    .valid_o (vs),
    .root_o  (root_s),
    .side_o  (it_s)
  );

  assign total = tbik_pkg::DistW'(cfg_i.upper) + tbik_pkg::DistW'(cfg_i.lower);

  always_comb begin
    it4_d = it_s;
    if (root_s < tbik_pkg::LenFloor) begin
      it4_d.dlen = tbik_pkg::LenFloor;
      it4_d.mag  = {32'd0, 32'd0, 32'(tbik_pkg::LenFloor)};
      it4_d.neg  = 3'b000;
    end else begin
      it4_d.dlen = root_s;
    end
    it4_d.reach_out = it4_d.dlen >= total;
  end

  assign q_valid_o = v4_q;
  assign q_item_o  = it4_q;

endmodule

// ===== hw/rtl/tbik_fifo.sv =====
// ----------------------------------------------------------------------------
// tbik_fifo
// Small queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tbik_fifo #(
  parameter int unsigned Depth = tbik_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  tbik_pkg::cls_item_t wr_item_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output tbik_pkg::cls_item_t rd_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tbik_pkg::cls_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign wr_ready_o = cnt_q != CntW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ===== hw/rtl/tbik_back.sv =====
// ----------------------------------------------------------------------------
// tbik_back
// Law-of-cosines solve, scaling along the goal direction, bend offset and
// saturation into the output register.
// ----------------------------------------------------------------------------
module tbik_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbik_pkg::cfg_t                   cfg_i,
  input  logic                             q_valid_i,
  output logic                             q_ready_o,
  input  tbik_pkg::cls_item_t              q_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0][tbik_pkg::CoordW-1:0] joint_o,
  output logic [2:0][tbik_pkg::CoordW-1:0] end_o,
  output logic                             out_of_reach_o
);

  localparam int unsigned NumW = tbik_pkg::NumW;
  localparam int unsigned AccW = tbik_pkg::AccW;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v7_q, v8_q;

  tbik_pkg::cls_item_t it1_q, it2_q, it4_q, it5_q;
  logic [61:0] uu1_q, ww1_q, uu2_q, uu4_q, uu5_q, pm2_5_q;
  logic [63:0] ll1_q;
  logic [NumW-1:0] num2_q, numer3_q;
  logic neg2_q, neg4_q;
  logic [tbik_pkg::DistW:0] den3_q;
  tbik_pkg::p_side_t ps3_q, ps_pd;
  logic vpd;
  logic [tbik_pkg::QuoW-1:0] q_pd;
  logic [tbik_pkg::LenW-1:0] pm4_q, pm_d;
  logic [2:0][63:0] pra5_q, prb5_q;
  logic [2:0] sa5_q;

  logic [63:0] hin;
  logic [2:0][NumW-1:0] numa, numb;
  tbik_pkg::h_side_t hs6, hs_o, hs7_q;
  logic vh;
  logic [31:0] h_o;
  logic [2:0][tbik_pkg::QuoW-1:0] qa, qb;
  logic [2:0] sa_o, sb_o;

  logic signed [AccW-1:0] ala7_q [3];
  logic signed [AccW-1:0] alb7_q [3];
  logic signed [AccW-1:0] perp7_q [3];

  logic [2:0][tbik_pkg::CoordW-1:0] joint8_q, end8_q;
  logic oor8_q;

  assign en        = !v8_q || out_ready_i;
  assign q_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= vpd;
      v5_q <= v4_q;
      v7_q <= vh;
      v8_q <= v7_q;
    end
  end

  // squares for the cosine numerator
  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q <= q_item_i;
      uu1_q <= cfg_i.upper * cfg_i.upper;
      ww1_q <= cfg_i.lower * cfg_i.lower;
      ll1_q <= q_item_i.dlen[31:0] * q_item_i.dlen[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NumW-1:0] a, b;
    if (en) begin
      a      = NumW'(uu1_q) + NumW'(ll1_q);
      b      = NumW'(ww1_q);
      neg2_q <= a < b;
      num2_q <= (a < b) ? b - a : a - b;
      it2_q  <= it1_q;
      uu2_q  <= uu1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NumW-1:0] numer;
    logic [tbik_pkg::DistW:0] den;
    logic ovf;
    if (en) begin
      numer      = num2_q + NumW'(it2_q.dlen);
      den        = {it2_q.dlen, 1'b0};
      ovf        = numer[NumW-1:32] >= den;
      numer3_q   <= ovf ? '0 : numer;
      den3_q     <= den;
      ps3_q.item <= it2_q;
      ps3_q.uu   <= uu2_q;
      ps3_q.ovf  <= ovf;
      ps3_q.neg  <= neg2_q;
    end
  end

  tbik_div #(
    .NumW  (NumW),
    .DenW  (tbik_pkg::DistW + 1),
    .QuoW  (tbik_pkg::QuoW),
    .SideW ($bits(tbik_pkg::p_side_t))
  ) u_cos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (numer3_q),
    .den_i   (den3_q),
    .side_i  (ps3_q),
    .valid_o (vpd),
    .quo_o   (q_pd),
    .side_o  (ps_pd)
  );

  // clamp cosine to [-1, 1]
  assign pm_d = (ps_pd.ovf || (q_pd > 32'(cfg_i.upper))) ? cfg_i.upper
                                                          : q_pd[tbik_pkg::LenW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      it4_q  <= ps_pd.item;
      uu4_q  <= ps_pd.uu;
      neg4_q <= ps_pd.neg;
      pm4_q  <= pm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] ka, kb;
    if (en) begin
      ka = it4_q.reach_out ? 32'(cfg_i.upper) : 32'(pm4_q);
      kb = 32'(cfg_i.upper) + 32'(cfg_i.lower);
      for (int i = 0; i < 3; i++) begin
        pra5_q[i] <= ka * it4_q.mag[i];
        prb5_q[i] <= kb * it4_q.mag[i];
        sa5_q[i]  <= it4_q.reach_out ? it4_q.neg[i] : (neg4_q ^ it4_q.neg[i]);
      end
      pm2_5_q <= pm4_q * pm4_q;
      uu5_q   <= uu4_q;
      it5_q   <= it4_q;
    end
  end

  always_comb begin
    hin = 64'(uu5_q - pm2_5_q);
    for (int i = 0; i < 3; i++) begin
      numa[i] = NumW'(pra5_q[i]) + NumW'(it5_q.dlen >> 1);
      numb[i] = NumW'(prb5_q[i]) + NumW'(it5_q.dlen >> 1);
    end
    hs6.root      = it5_q.root;
    hs6.goal      = it5_q.goal;
    hs6.bend      = it5_q.bend;
    hs6.reach_out = it5_q.reach_out;
  end

  tbik_sqrt #(
    .RootW (32),
    .SideW ($bits(tbik_pkg::h_side_t))
  ) u_sin_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .rad_i   (hin),
    .side_i  (hs6),
    .valid_o (vh),
    .root_o  (h_o),
    .side_o  (hs_o)
  );

  for (genvar i = 0; i < 3; i++) begin : g_axis
    tbik_div #(
      .NumW  (NumW),
      .DenW  (tbik_pkg::DistW),
      .QuoW  (tbik_pkg::QuoW),
      .SideW (1)
    ) u_div_a (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v5_q),
      .num_i   (numa[i]),
      .den_i   (it5_q.dlen),
      .side_i  (sa5_q[i]),
      .valid_o (),
      .quo_o   (qa[i]),
      .side_o  (sa_o[i])
    );

    tbik_div #(
      .NumW  (NumW),
      .DenW  (tbik_pkg::DistW),
      .QuoW  (tbik_pkg::QuoW),
      .SideW (1)
    ) u_div_b (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v5_q),
      .num_i   (numb[i]),
      .den_i   (it5_q.dlen),
      .side_i  (it5_q.neg[i]),
      .valid_o (),
      .quo_o   (qb[i]),
      .side_o  (sb_o[i])
    );
  end

  // bend offset and signed along-direction terms
  always_ff @(posedge clk_i) begin
    logic [tbik_pkg::BendW-1:0] bm;
    logic [49:0] pp;
    logic [AccW-1:0] pr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        bm = hs_o.bend[i][tbik_pkg::BendW-1] ? -hs_o.bend[i] : hs_o.bend[i];
        pp = (50'(h_o) * 50'(bm)) + tbik_pkg::RoundHalf;
        pr = AccW'(pp >> tbik_pkg::FracW);
        perp7_q[i] <= hs_o.bend[i][tbik_pkg::BendW-1] ? $signed(-pr) : $signed(pr);
        ala7_q[i]  <= sa_o[i] ? $signed(-AccW'(qa[i])) : $signed(AccW'(qa[i]));
        alb7_q[i]  <= sb_o[i] ? $signed(-AccW'(qb[i])) : $signed(AccW'(qb[i]));
      end
      hs7_q <= hs_o;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [AccW-1:0] rt;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rt = AccW'($signed(hs7_q.root[i]));
        if (hs7_q.reach_out) begin
          joint8_q[i] <= tbik_pkg::sat32(rt + ala7_q[i]);
          end8_q[i]   <= tbik_pkg::sat32(rt + alb7_q[i]);
        end else begin
          joint8_q[i] <= tbik_pkg::sat32(rt + ala7_q[i] + perp7_q[i]);
          end8_q[i]   <= hs7_q.goal[i];
        end
      end
      oor8_q <= hs7_q.reach_out;
    end
  end

  assign out_valid_o    = v8_q;
  assign joint_o        = joint8_q;
  assign end_o          = end8_q;
  assign out_of_reach_o = oor8_q;

endmodule

// ===== hw/rtl/tbik_port_checker.sv =====
// ----------------------------------------------------------------------------
// tbik_port_checker
// Port-level checks of the solver's output channel, bound to the top level.
// ----------------------------------------------------------------------------
module tbik_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] joint_x_i,
  input logic [31:0] joint_y_i,
  input logic [31:0] joint_z_i,
  input logic [31:0] end_x_i,
  input logic [31:0] end_y_i,
  input logic [31:0] end_z_i,
  input logic        out_of_reach_i
);

  logic [15:0] cnt_q;
  logic in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_beat && !out_beat) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({joint_x_i, joint_y_i, joint_z_i,
                                             end_x_i, end_y_i, end_z_i,
                                             out_of_reach_i}))
    else $error("out payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("out beat without an outstanding input beat");

endmodule

bind two_bone_ik_solver tbik_port_checker u_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .joint_x_i      (joint_x_o),
  .joint_y_i      (joint_y_o),
  .joint_z_i      (joint_z_o),
  .end_x_i        (end_x_o),
  .end_y_i        (end_y_o),
  .end_z_i        (end_z_o),
  .out_of_reach_i (out_of_reach_o)
);

// ===== tb/two_bone_ik_checker.sv =====
// ----------------------------------------------------------------------------
// two_bone_ik_checker
// Watches the cfg, in and out channels of the two-bone IK solver. It keeps
// its own copy of the limb lengths, predicts the joint and end positions of
// every accepted pose, and compares each output beat with the oldest
// prediction. It reports mismatches and the number of predictions still open.
// ----------------------------------------------------------------------------
module two_bone_ik_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [tbik_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbik_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [31:0]            root_x_i,
  input  logic signed [31:0]            root_y_i,
  input  logic signed [31:0]            root_z_i,
  input  logic signed [31:0]            goal_x_i,
  input  logic signed [31:0]            goal_y_i,
  input  logic signed [31:0]            goal_z_i,
  input  logic signed [17:0]            bend_x_i,
  input  logic signed [17:0]            bend_y_i,
  input  logic signed [17:0]            bend_z_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [31:0]            joint_x_i,
  input  logic signed [31:0]            joint_y_i,
  input  logic signed [31:0]            joint_z_i,
  input  logic signed [31:0]            end_x_i,
  input  logic signed [31:0]            end_y_i,
  input  logic signed [31:0]            end_z_i,
  input  logic                          out_of_reach_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] jx, jy, jz, ex, ey, ez;
    logic        oor;
  } limb_pos_t;

  limb_pos_t                 solved_q[$];
  logic [tbik_pkg::LenW-1:0] upper_len, lower_len;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (n >= t * t) r = t;
    end
    return r[63:0];
  endfunction

  function automatic longint scale_dir(longint k, longint d, longint unsigned len);
    logic [127:0] prod;
    longint unsigned m;
    prod = 128'(mag64(k)) * 128'(mag64(d)) + 128'(len >> 1);
    m = 64'(prod / 128'(len));
    return ((k < 0) != (d < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic limb_pos_t solve_limb(longint root[3], longint goal[3],
                                           longint bend[3]);
    longint d[3], j[3], e[3];
    longint unsigned len, u, w, total, pm, h, bm;
    logic [127:0] sq, a, b, num;
    logic neg;
    longint pc;
    limb_pos_t r;
    u = upper_len;
    w = lower_len;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = goal[i] - root[i];
      sq += 128'(mag64(d[i])) * 128'(mag64(d[i]));
    end
    len = isqrt(sq);
    if (len < 7) begin
      len = 7;
      d[0] = 7;
      d[1] = 0;
      d[2] = 0;
    end
    total = u + w;
    if (len >= total) begin
      for (int i = 0; i < 3; i++) begin
        j[i] = root[i] + scale_dir(u, d[i], len);
        e[i] = root[i] + scale_dir(total, d[i], len);
      end
      r.oor = 1'b1;
    end else begin
      pc = 0;
      if (u != 0) begin
        a = 128'(u) * 128'(u) + 128'(len) * 128'(len);
        b = 128'(w) * 128'(w);
        neg = a < b;
        num = neg ? b - a : a - b;
        pm = 64'((num + 128'(len)) / (128'(len) << 1));
        if (pm > u) pm = u;
        pc = neg ? -longint'(pm) : longint'(pm);
      end
      h = isqrt(128'(u * u - mag64(pc) * mag64(pc)));
      for (int i = 0; i < 3; i++) begin
        bm = (h * mag64(bend[i]) + 64'd32768) >> 16;
        j[i] = root[i] + scale_dir(pc, d[i], len) + (bend[i] < 0 ? -longint'(bm) : bm);
        e[i] = goal[i];
      end
      r.oor = 1'b0;
    end
    r.jx = clip32(j[0]);
    r.jy = clip32(j[1]);
    r.jz = clip32(j[2]);
    r.ex = clip32(e[0]);
    r.ey = clip32(e[1]);
    r.ez = clip32(e[2]);
    return r;
  endfunction

  assign pending_o = solved_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    longint root[3], goal[3], bend[3];
    limb_pos_t exp_pos, got;
    if (!rst_ni) begin
      upper_len    <= tbik_pkg::LenW'(65536);
      lower_len    <= tbik_pkg::LenW'(65536);
      fail_count_o <= 0;
      solved_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tbik_pkg::CfgUpperLength) begin
          upper_len <= cfg_data_i[tbik_pkg::LenW-1:0];
        end else if (cfg_index_i == tbik_pkg::CfgLowerLength) begin
          lower_len <= cfg_data_i[tbik_pkg::LenW-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        root = '{root_x_i, root_y_i, root_z_i};
        goal = '{goal_x_i, goal_y_i, goal_z_i};
        bend = '{bend_x_i, bend_y_i, bend_z_i};
        solved_q.push_back(solve_limb(root, goal, bend));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{joint_x_i, joint_y_i, joint_z_i, end_x_i, end_y_i, end_z_i,
                out_of_reach_i};
        if (solved_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected out beat %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_pos = solved_q.pop_front();
          if (got !== exp_pos) begin
            if (fail_count_o < 10) begin
              $display("mismatch joint exp %h %h %h got %h %h %h",
                       exp_pos.jx, exp_pos.jy, exp_pos.jz, got.jx, got.jy, got.jz);
              $display("         end   exp %h %h %h got %h %h %h, oor exp %b got %b",
                       exp_pos.ex, exp_pos.ey, exp_pos.ez, got.ex, got.ey, got.ez,
                       exp_pos.oor, got.oor);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_two_bone_ik_solver.sv =====
// ----------------------------------------------------------------------------
// tb_two_bone_ik_solver
// Drives the two-bone IK solver with directed and random poses over several
// limb length settings, with bursty input and random output stalls. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_two_bone_ik_solver;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [tbik_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [tbik_pkg::CfgDataW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, out_of_reach_o;
  logic signed [31:0] root_x_i, root_y_i, root_z_i, goal_x_i, goal_y_i, goal_z_i;
  logic signed [17:0] bend_x_i, bend_y_i, bend_z_i;
  logic signed [31:0] joint_x_o, joint_y_o, joint_z_o, end_x_o, end_y_o, end_z_o;
  int fail_count, pending;
  int stall_mode;
  int burst_left;
  longint unsigned cur_total;

  two_bone_ik_solver uut (.*);

  two_bone_ik_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o), .root_x_i, .root_y_i,
    .root_z_i, .goal_x_i, .goal_y_i, .goal_z_i, .bend_x_i, .bend_y_i, .bend_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .joint_x_i(joint_x_o),
    .joint_y_i(joint_y_o), .joint_z_i(joint_z_o), .end_x_i(end_x_o),
    .end_y_i(end_y_o), .end_z_i(end_z_o), .out_of_reach_i(out_of_reach_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8ms;
    $display("FAIL two_bone_ik_solver");
    $finish;
  end

  // output stall pattern; the mode is redrawn at random among four readiness levels
  always @(posedge clk_i) begin
    if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 99) >= 20;
      2: out_ready_i <= $urandom_range(0, 99) >= 70;
      default: out_ready_i <= $urandom_range(0, 99) >= 95;
    endcase
  end

  function automatic longint rnd_span(longint unsigned span);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % (2 * span + 1)) - longint'(span);
  endfunction

  function automatic logic [31:0] sat_c(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [tbik_pkg::CfgIdxW-1:0] idx,
                           logic [tbik_pkg::CfgDataW-1:0] val);
    logic r;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      r = cfg_ready_o;
      @(posedge clk_i);
    end while (!r);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_lengths(longint unsigned u, longint unsigned w);
    wait_drain();
    cfg_write(tbik_pkg::CfgUpperLength, {1'($urandom), u[30:0]});
    cfg_write(tbik_pkg::CfgLowerLength, {1'($urandom), w[30:0]});
    cfg_write(tbik_pkg::CfgIdxW'($urandom_range(2, 15)), $urandom);
    cur_total = u + w;
  endtask

  task automatic send_pose(longint rx, ry, rz, gx, gy, gz, bx, by, bz);
    logic r;
    root_x_i <= rx[31:0];
    root_y_i <= ry[31:0];
    root_z_i <= rz[31:0];
    goal_x_i <= gx[31:0];
    goal_y_i <= gy[31:0];
    goal_z_i <= gz[31:0];
    bend_x_i <= bx[17:0];
    bend_y_i <= by[17:0];
    bend_z_i <= bz[17:0];
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      r = in_ready_o;
      @(posedge clk_i);
    end while (!r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  task automatic rand_pose();
    longint r[3], g[3], bnd[3];
    longint unsigned span;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      r[i] = ($urandom_range(0, 3) == 0) ? longint'(signed'($urandom))
                                         : rnd_span(64'd1 << $urandom_range(4, 24));
      bnd[i] = rnd_span(65536);
    end
    span = cur_total / 2 + 1;
    for (int i = 0; i < 3; i++) begin
      case (kind)
        0, 1:    g[i] = longint'(signed'($urandom));
        2:       g[i] = r[i] + rnd_span(cur_total + 16);
        3:       g[i] = r[i] + rnd_span(4);
        default: g[i] = r[i] + rnd_span(span);
      endcase
      g[i] = longint'(signed'(sat_c(g[i])));
    end
    if (kind == 9) begin
      bnd = '{0, 0, 0};
      bnd[$urandom_range(0, 2)] = ($urandom & 1) ? 65536 : -65536;
    end
    send_pose(r[0], r[1], r[2], g[0], g[1], g[2], bnd[0], bnd[1], bnd[2]);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b1;
    stall_mode = 0;
    burst_left = 0;
    cur_total = 131072;
    {root_x_i, root_y_i, root_z_i, goal_x_i, goal_y_i, goal_z_i} = '0;
    {bend_x_i, bend_y_i, bend_z_i} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at reset lengths and then at edge-case length settings
    send_pose(0, 0, 0, 0, 0, 0, 0, 65536, 0);
    send_pose(100, -5, 9, 103, -3, 8, 0, 0, -65536);
    send_pose(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
    send_pose(0, 0, 0, 131072, 0, 0, 0, 65536, 0);
    send_pose(0, 0, 0, 0, 98304, 0, 65536, 0, 0);
    send_pose(0, 0, 0, 0, 0, 1000, -65536, -65536, -65536);
    send_pose(2147483647, 2147483647, 2147483647, -2147483648, -2147483648,
              -2147483648, 65536, 65536, 65536);
    send_pose(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647,
              2147483647, -65536, -1, 1);
    send_pose(2147483600, 0, 0, 2147483647, 60000, 0, 65536, 65536, 0);
    send_pose(-2147483600, 0, 0, -2147483647, -60000, 0, -65536, -65536, 0);
    send_pose(5, 5, 5, 5, 5, 5, 65535, -65535, 0);
    set_lengths(0, 65536);
    send_pose(0, 0, 0, 30000, 20000, 0, 0, 0, 65536);
    send_pose(0, 0, 0, 0, 0, 0, 0, 65536, 0);
    set_lengths(65536, 0);
    send_pose(0, 0, 0, 30000, 20000, 0, 0, 0, 65536);
    set_lengths(196608, 65536);
    send_pose(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
    send_pose(0, 0, 0, 1000, 0, 0, 0, 65536, 0);
    set_lengths(0, 0);
    send_pose(0, 0, 0, 0, 0, 0, 0, 65536, 0);
    send_pose(1, 2, 3, 400, -500, 600, 0, 0, 65536);
    set_lengths(2147483647, 2147483647);
    send_pose(0, 0, 0, 0, 0, 0, 65536, 0, 0);
    send_pose(-2147483648, 0, 0, 2147483647, 0, 0, 0, 65536, 0);
    send_pose(100, 200, 300, -100, 9000, 2147483647, -65536, 65536, -65536);

    // random phases over length settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_lengths(65536, 65536);
        1: set_lengths($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
        2: set_lengths(0, $urandom_range(1, 1 << 22));
        3: set_lengths($urandom_range(1, 1 << 22), 0);
        4: set_lengths(2147483647, $urandom_range(0, 2147483647));
        5: set_lengths($urandom_range(1 << 24, 2147483647), 2147483647);
        default: set_lengths($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18));
      endcase
      repeat (240) rand_pose();
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS two_bone_ik_solver");
    end else begin
      $display("FAIL two_bone_ik_solver");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tbik_pkg.sv
hw/rtl/tbik_sqrt.sv
hw/rtl/tbik_div.sv
hw/rtl/tbik_front.sv
hw/rtl/tbik_fifo.sv
hw/rtl/tbik_back.sv
hw/rtl/two_bone_ik_solver.sv
hw/rtl/tbik_port_checker.sv
tb/two_bone_ik_checker.sv
tb/tb_two_bone_ik_solver.sv
